### design/tlrp_pkg.sv
`default_nettype none
package tlrp_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 32;
  localparam int unsigned PAYLOAD_BYTES_MAX = 32;
  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES_MAX + 1);
  localparam int unsigned LINE_END_ROOM = 3;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic [31:0] dest_node;
    logic [2:0]  dest_port;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic [31:0] packet_node;
    logic [2:0]  packet_port;
    logic        packet_end;
  } out_item_t;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [31:0]      node;
    logic [2:0]       port;
    logic             crlf;
    logic             zero;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage
`default_nettype wire

### design/tlrp_ram.sv
`default_nettype none
module tlrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/tlrp_cmd_fifo.sv
`default_nettype none
module tlrp_cmd_fifo
  import tlrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### design/tlrp_front.sv
`default_nettype none
module tlrp_front
  import tlrp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int unsigned IDX_W = $clog2(PAYLOAD_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire in_item_t         item_i,
  output logic                  full_o,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o,
  input  wire logic             cmd_full_i,
  input  wire done_t            done_i,
  output logic                  we_o,
  output logic [IDX_W:0]        waddr_o,
  output logic [7:0]            wdata_o
);

  in_item_t         in_q;
  logic             in_valid_q, in_valid_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [31:0]      node_q, node_d;
  logic [2:0]       port_q, port_d;

  logic             chg, flush_chg, is_eol, is_nul, store, line, full_flush;
  logic             need_cmd, go, bank_eff, crlf_room;
  logic [IDX_W-1:0] fill_eff;
  logic [IDX_W:0]   fill_inc;

  assign full_o = in_valid_q;

  always_comb begin
    chg        = (in_q.dest_node != node_q) || (in_q.dest_port != port_q);
    flush_chg  = chg && (fill_q != '0);
    fill_eff   = flush_chg ? '0 : fill_q;
    bank_eff   = flush_chg ? ~bank_q : bank_q;
    is_nul     = (in_q.text_byte == CH_NUL);
    is_eol     = (in_q.text_byte == CH_CR) || (in_q.text_byte == CH_LF);
    store      = !is_nul && !is_eol;
    line       = is_eol && (fill_eff != '0);
    fill_inc   = {1'b0, fill_eff} + {{IDX_W{1'b0}}, 1'b1};
    full_flush = store && (fill_inc == (IDX_W+1)'(PAYLOAD_BYTES));
    crlf_room  = {1'b0, fill_eff} < (IDX_W+1)'(PAYLOAD_BYTES - LINE_END_ROOM);
    need_cmd   = flush_chg || line || full_flush;
    go         = in_valid_q && (!need_cmd || !cmd_full_i) && (!store || !busy_q[bank_eff]);

    cmd_o.bank  = flush_chg ? bank_q : bank_eff;
    cmd_o.count = full_flush ? CNT_W'(PAYLOAD_BYTES) : CNT_W'(fill_q);
    cmd_o.node  = flush_chg ? node_q : in_q.dest_node;
    cmd_o.port  = flush_chg ? port_q : in_q.dest_port;
    cmd_o.crlf  = line && crlf_room;
    cmd_o.zero  = !full_flush;
    cmd_push_o  = go && need_cmd;

    we_o    = go && store;
    waddr_o = {bank_eff, fill_eff};
    wdata_o = in_q.text_byte;

    in_valid_d = (in_valid_q && !go) || (push_i && !in_valid_q);
    fill_d     = fill_q;
    bank_d     = bank_q;
    node_d     = node_q;
    port_d     = port_q;
    if (go) begin
      node_d = in_q.dest_node;
      port_d = in_q.dest_port;
      if (store && !full_flush) begin
        fill_d = fill_inc[IDX_W-1:0];
      end else if (store || line) begin
        fill_d = '0;
      end else begin
        fill_d = fill_eff;
      end
      bank_d = (line || full_flush) ? ~bank_eff : bank_eff;
    end

    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (cmd_push_o) begin
      busy_d[cmd_o.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !in_valid_q) begin
      in_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      fill_q     <= '0;
      bank_q     <= 1'b0;
      busy_q     <= 2'b00;
      node_q     <= '0;
      port_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      fill_q     <= fill_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
      node_q     <= node_d;
      port_q     <= port_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> !busy_q[bank_eff])
    else $error("write into a bank still being drained");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> !busy_q[bank_q])
    else $error("gathering bank marked busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i.valid |-> busy_q[done_i.bank])
    else $error("drain done for an idle bank");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |=> busy_q[$past(cmd_o.bank)])
    else $error("flushed bank not held");

endmodule
`default_nettype wire

### design/tlrp_back.sv
`default_nettype none
module tlrp_back
  import tlrp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int unsigned IDX_W = $clog2(PAYLOAD_BYTES)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  input  wire logic            cmd_empty_i,
  output logic                 cmd_pop_o,
  output done_t                done_o,
  output logic                 re_o,
  output logic [IDX_W:0]       raddr_o,
  input  wire logic [7:0]      rdata_i,
  input  wire logic            pop_i,
  output out_item_t            out_o,
  output logic                 empty_o
);

  localparam int unsigned STEP_W = $clog2(PAYLOAD_BYTES + 4);

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] count_ext, total, tail;
  logic              last, in_ram, issue, room;

  out_item_t         meta_q, meta_d;
  logic              use_ram_q;
  logic              rd_valid_q;

  out_item_t         oq_q [4];
  logic [1:0]        owptr_q, orptr_q;
  logic [2:0]        ocnt_q, ocnt_d;
  logic              opop;
  out_item_t         oentry;

  always_comb begin
    count_ext = STEP_W'(cmd_i.count);
    total     = count_ext + {{(STEP_W-2){1'b0}}, cmd_i.crlf, 1'b0}
                + {{(STEP_W-1){1'b0}}, cmd_i.zero};
    last      = (step_q == total - STEP_W'(1));
    in_ram    = step_q < count_ext;
    tail      = step_q - count_ext;
    room      = ({2'b00, rd_valid_q} + ocnt_q) < 3'd4;
    issue     = !cmd_empty_i && room;

    step_d    = step_q;
    if (issue) begin
      step_d = last ? '0 : step_q + STEP_W'(1);
    end
    cmd_pop_o    = issue && last;
    done_o.valid = issue && last;
    done_o.bank  = cmd_i.bank;
    re_o         = issue && in_ram;
    raddr_o      = {cmd_i.bank, step_q[IDX_W-1:0]};

    meta_d.packet_node = cmd_i.node;
    meta_d.packet_port = cmd_i.port;
    meta_d.packet_end  = last;
    if (cmd_i.crlf && tail == '0) begin
      meta_d.packet_byte = CH_CR;
    end else if (cmd_i.crlf && tail == STEP_W'(1)) begin
      meta_d.packet_byte = CH_LF;
    end else begin
      meta_d.packet_byte = CH_NUL;
    end

    oentry = meta_q;
    if (use_ram_q) begin
      oentry.packet_byte = rdata_i;
    end

    opop   = pop_i && (ocnt_q != 3'd0);
    ocnt_d = ocnt_q + {2'b00, rd_valid_q} - {2'b00, opop};
  end

  assign empty_o = (ocnt_q == 3'd0);
  assign out_o   = oq_q[orptr_q];

  always_ff @(posedge clk_i) begin
    if (issue) begin
      meta_q    <= meta_d;
      use_ram_q <= in_ram;
    end
    if (rd_valid_q) begin
      oq_q[owptr_q] <= oentry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      rd_valid_q <= 1'b0;
      owptr_q    <= 2'd0;
      orptr_q    <= 2'd0;
      ocnt_q     <= 3'd0;
    end else begin
      step_q     <= step_d;
      rd_valid_q <= issue;
      owptr_q    <= owptr_q + {1'b0, rd_valid_q};
      orptr_q    <= orptr_q + {1'b0, opop};
      ocnt_q     <= ocnt_d;
    end
  end

endmodule
`default_nettype wire

### design/text_line_radio_packetizer.sv
// Channel   Handshake      Payload     Moves
// input     push / full    item_i      one text byte with its destination
// result    pop / empty    result_o    one payload byte with destination and end flag
//
// An item is accepted into an input register and classified in the following cycle,
// with full held high until it is taken: no new item enters before then. A payload
// flush streams one byte per cycle while the output queue has room, out of the line
// RAM, which holds two banks so the next line gathers while the last one drains.
// Input stalls while a flush meets a full command queue or the write bank is draining.
// Reset clears all control state; the line RAM is not cleared.
`default_nettype none
module text_line_radio_packetizer
  import tlrp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item_i,
  input  wire logic     pop,
  output logic          empty,
  output out_item_t     result_o
);

  localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int unsigned DEPTH = 2 ** (IDX_W + 1);

  cmd_t           f_cmd, b_cmd;
  logic           f_cmd_push, q_full, q_empty, b_cmd_pop;
  done_t          done;
  logic           we, re;
  logic [IDX_W:0] waddr, raddr;
  logic [7:0]     wdata, rdata;

  tlrp_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .IDX_W(IDX_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .cmd_push_o(f_cmd_push),
    .cmd_o     (f_cmd),
    .cmd_full_i(q_full),
    .done_i    (done),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata)
  );

  tlrp_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_cmd_push),
    .data_i (f_cmd),
    .full_o (q_full),
    .pop_i  (b_cmd_pop),
    .data_o (b_cmd),
    .empty_o(q_empty)
  );

  tlrp_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tlrp_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .IDX_W(IDX_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (b_cmd),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (b_cmd_pop),
    .done_o     (done),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .pop_i      (pop),
    .out_o      (result_o),
    .empty_o    (empty)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import tlrp_pkg::*;

  localparam int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [31:0] node;
    logic [2:0]  port;
  } dest_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item_i = '0;
  logic      pop = 1'b0;
  logic      empty;
  out_item_t result_o;

  in_item_t  pending_q[$];
  out_item_t payload_q[$];

  logic [7:0]  line_buf[PAYLOAD_BYTES];
  int          line_fill = 0;
  logic [31:0] cur_node = '0;
  logic [2:0]  cur_port = '0;

  int n_items = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_flush = 0;
  int n_lines = 0;
  int n_errors = 0;

  int  in_gap = 0;
  int  out_wait = 0;
  int  in_quiet = 0;
  int  out_quiet = 0;
  bit  drv_free;
  int  out_wait_n;

  text_line_radio_packetizer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .pop     (pop),
    .empty   (empty),
    .result_o(result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d of %0d items accepted, %0d bytes outstanding",
             n_accepted, n_items, payload_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      quiet_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic void emit(logic [7:0] b, logic [31:0] n, logic [2:0] p, logic e);
    out_item_t r;
    r.packet_byte = b;
    r.packet_node = n;
    r.packet_port = p;
    r.packet_end  = e;
    payload_q.push_back(r);
  endfunction

  function automatic void emit_stored(logic [31:0] n, logic [2:0] p, bit last_end);
    for (int i = 0; i < line_fill; i++) begin
      emit(line_buf[i], n, p, last_end && (i == line_fill - 1));
    end
  endfunction

  function automatic void predict_payload(in_item_t it);
    if (it.dest_node != cur_node || it.dest_port != cur_port) begin
      if (line_fill > 0) begin
        emit_stored(cur_node, cur_port, 1'b0);
        emit(CH_NUL, cur_node, cur_port, 1'b1);
        n_flush++;
      end
      line_fill = 0;
      cur_node  = it.dest_node;
      cur_port  = it.dest_port;
    end
    if (it.text_byte == CH_NUL) begin
      // carries no character
    end else if (it.text_byte != CH_CR && it.text_byte != CH_LF) begin
      line_buf[line_fill] = it.text_byte;
      line_fill++;
      if (line_fill >= PAYLOAD_BYTES) begin
        emit_stored(it.dest_node, it.dest_port, 1'b1);
        line_fill = 0;
        n_full++;
      end
    end else if (line_fill > 0) begin
      emit_stored(it.dest_node, it.dest_port, 1'b0);
      if (line_fill < PAYLOAD_BYTES - LINE_END_ROOM) begin
        emit(CH_CR, it.dest_node, it.dest_port, 1'b0);
        emit(CH_LF, it.dest_node, it.dest_port, 1'b0);
      end
      emit(CH_NUL, it.dest_node, it.dest_port, 1'b1);
      line_fill = 0;
      n_lines++;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("%0t ns: byte %0d %s: got 0x%0h, want 0x%0h", $time, n_checked, what, got, want);
  endtask

  task automatic check_payload_byte(out_item_t got);
    out_item_t want;
    if (payload_q.size() == 0) begin
      report_mismatch("unexpected byte", 32'(got.packet_byte), '0);
    end else begin
      want = payload_q.pop_front();
      if (got.packet_byte !== want.packet_byte)
        report_mismatch("packet_byte", 32'(got.packet_byte), 32'(want.packet_byte));
      if (got.packet_node !== want.packet_node)
        report_mismatch("packet_node", got.packet_node, want.packet_node);
      if (got.packet_port !== want.packet_port)
        report_mismatch("packet_port", 32'(got.packet_port), 32'(want.packet_port));
      if (got.packet_end !== want.packet_end)
        report_mismatch("packet_end", 32'(got.packet_end), 32'(want.packet_end));
    end
    n_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      in_gap <= 0;
    end else begin
      drv_free = !push || !full;
      if (push && !full) begin
        predict_payload(item_i);
        n_accepted++;
      end
      if (drv_free) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          push   <= 1'b0;
        end else if (pending_q.size() > 0) begin
          item_i <= pending_q.pop_front();
          push   <= 1'b1;
          in_gap <= draw_gap(in_quiet);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      out_wait <= 0;
    end else begin
      out_wait_n = out_wait;
      if (pop && !empty) begin
        check_payload_byte(result_o);
        out_wait_n = draw_gap(out_quiet);
      end
      if (out_wait_n > 0) begin
        pop      <= 1'b0;
        out_wait <= out_wait_n - 1;
      end else begin
        pop      <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  function automatic void queue_item(logic [7:0] b, dest_t d);
    in_item_t it;
    it.text_byte = b;
    it.dest_node = d.node;
    it.dest_port = d.port;
    pending_q.push_back(it);
    n_items++;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic int line_length();
    case ($urandom_range(0, 8))
      0:       return 0;
      1, 2, 3: return $urandom_range(1, 8);
      4, 5:    return $urandom_range(9, 28);
      6, 7:    return $urandom_range(PAYLOAD_BYTES - LINE_END_ROOM, PAYLOAD_BYTES);
      default: return $urandom_range(PAYLOAD_BYTES + 1, 2 * PAYLOAD_BYTES + 6);
    endcase
  endfunction

  initial begin
    dest_t dests[4];
    dest_t d0, dmax, d1, d2;
    int    sel;
    int    roll;
    int    len;
    int    n_load;

    d0   = '{node: 32'h0000_0000, port: 3'd0};
    dmax = '{node: 32'hFFFF_FFFF, port: 3'd7};
    d1   = '{node: 32'h5555_5555, port: 3'd4};
    d2   = '{node: 32'hAAAA_AAAA, port: 3'd5};

    // directed: line ends, empty lines, zero bytes, destination flushes, extremes
    queue_item(8'h41, d0);
    queue_item(CH_CR, d0);
    queue_item(CH_LF, d0);
    queue_item(CH_CR, d0);
    queue_item(8'hFF, dmax);
    queue_item(8'h01, dmax);
    queue_item(CH_NUL, dmax);
    queue_item(8'h80, d1);
    queue_item(CH_NUL, d2);
    queue_item(CH_LF, d2);
    queue_item(8'h7F, d2);
    queue_item(8'hFE, d2);
    queue_item(CH_LF, d2);
    queue_item(CH_NUL, d0);
    queue_item(8'h20, d1);
    queue_item(8'h0B, dmax);
    queue_item(CH_CR, dmax);
    queue_item(CH_LF, dmax);

    dests[0] = d0;
    dests[1] = dmax;
    dests[2] = '{node: $urandom(), port: 3'($urandom_range(0, 7))};
    dests[3] = '{node: $urandom(), port: 3'($urandom_range(0, 7))};
    sel    = 0;
    n_load = 0;
    while (n_load < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) sel = $urandom_range(0, 3);
      if (roll < 4) begin
        dests[sel].node = $urandom();
        dests[sel].port = 3'($urandom_range(0, 7));
      end
      if (roll < 80) begin
        len = line_length();
        repeat (len) queue_item(text_char(), dests[sel]);
        queue_item($urandom_range(0, 1) ? CH_CR : CH_LF, dests[sel]);
        n_load += len + (len > 0);
        if ($urandom_range(0, 9) == 0) queue_item(CH_LF, dests[sel]);
      end else if (roll < 90) begin
        // drop the line end and switch destination mid-line
        len = $urandom_range(1, 12);
        repeat (len) queue_item(text_char(), dests[sel]);
        n_load += len;
        sel = (sel + $urandom_range(1, 3)) % 4;
        if ($urandom_range(0, 1)) queue_item(CH_NUL, dests[sel]);
      end else begin
        queue_item(8'($urandom_range(0, 255)), dests[$urandom_range(0, 3)]);
        n_load++;
      end
    end

    @(posedge rst_ni);
    while (n_accepted < n_items || payload_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("run covered %0d items and %0d payload bytes: %0d lines, %0d full payloads,",
             n_accepted, n_checked, n_lines, n_full);
    $display("  %0d destination flushes, %0d mismatches", n_flush, n_errors);
    if (n_errors == 0 && payload_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/tlrp_pkg.sv
design/tlrp_ram.sv
design/tlrp_cmd_fifo.sv
design/tlrp_front.sv
design/tlrp_back.sv
design/text_line_radio_packetizer.sv
verif/tb_top.sv
